### design/table_key_search_defines.svh
// ----------------------------------------------------------------------------
// table_key_search_defines.svh
// Assertion macros shared by the table key search RTL.
// ----------------------------------------------------------------------------
`ifndef TABLE_KEY_SEARCH_DEFINES_SVH
`define TABLE_KEY_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define TKS_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");
// Condition must never be seen outside reset.
`define TKS_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define TKS_ASSERT(label, prop)
`define TKS_NEVER(label, cond)
`endif

`endif

### design/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Sizes and codes of the table key search block.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WORD_W      = 32;

	// request kinds (tuser)
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// search methods
	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_BINARY = 1'b1;

	// configuration register indexes
	localparam logic REG_SEARCH_MODE = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	// stream widths, padded to whole bytes
	localparam int S_DATA_BITS = IDX_W + 2 * WORD_W;
	localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
	localparam int M_DATA_BITS = 1 + CNT_W;
	localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

### design/table_key_search.sv
// ----------------------------------------------------------------------------
// table_key_search
// Word table with a linear or binary key search run on one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: tuser selects a load (0) or a search (1). A load writes
//    entry_value at entry_index and gives no result item.
//  - A search walks the table through one memory read port and one equality /
//    signed-less-than comparator, each comparison a read step then a compare
//    step. The comparison count is up to 256 in linear mode and up to 9 in
//    binary mode.
//  - s_tready is low while a search is running; loads are taken while idle.
//  - Master stream: one result item per search, held in an output register.
//    A finished search waits for that register only if the previous result
//    has not been taken; the next item is accepted once it is stored.
//  - Config port: cfg_we/cfg_index/cfg_data, to be written only while idle;
//    the block does not enforce this. entry_count over the depth means full depth.
//  - Reset clears control state and configuration; table contents are
//    undefined until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none
`include "table_key_search_defines.svh"

module table_key_search
	import tks_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slave stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // entry_index, entry_value, search_key
	input  wire logic                s_tuser,  // req_type
	// master stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // found, comparison_count, zero pad
	// configuration
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [CNT_W-1:0]    cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic              mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_p1_q;
	logic [CNT_W-1:0]  addr_q;
	logic [CNT_W-1:0]  cmp_q;
	logic              found_q;
	logic [WORD_W-1:0] key_q;
	logic              m_valid_q;
	logic              out_found_q;
	logic [CNT_W-1:0]  out_cmp_q;

	logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// input fields
	logic [IDX_W-1:0]  in_index;
	logic [WORD_W-1:0] in_value;
	logic [WORD_W-1:0] in_key;
	logic              accept;
	logic              load_we;
	logic [CNT_W-1:0]  used_count;
	logic [CNT_W:0]    mid_sum;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  probe;
	logic              match;
	logic              key_less;
	logic [CNT_W-1:0]  next_lo;
	logic [CNT_W-1:0]  next_hi_p1;
	logic              out_free;

	assign in_index = s_tdata[IDX_W-1:0];
	assign in_value = s_tdata[IDX_W+WORD_W-1:IDX_W];
	assign in_key   = s_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_we  = accept && (s_tuser == REQ_LOAD);
	assign out_free = !m_valid_q || m_tready;

	assign used_count = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;

	// probe address: next index in linear mode, floor midpoint in binary mode
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_p1_q} - (CNT_W+1)'(1);
	assign mid     = mid_sum[CNT_W:1];
	assign probe   = (mode_q == MODE_BINARY) ? mid : lo_q;

	// shared comparator and range update
	assign match    = (rdata_q == key_q);
	assign key_less = ($signed(key_q) < $signed(rdata_q));

	always_comb begin
		next_lo    = lo_q;
		next_hi_p1 = hi_p1_q;
		if (mode_q == MODE_LINEAR) begin
			next_lo = lo_q + CNT_W'(1);
		end else if (key_less) begin
			next_hi_p1 = addr_q;
		end else begin
			next_lo = addr_q + CNT_W'(1);
		end
	end

	// table memory: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem_q[in_index] <= in_value;
		end
		if (state_q == ST_RD) begin
			rdata_q <= mem_q[probe[IDX_W-1:0]];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LINEAR;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEARCH_MODE: mode_q  <= cfg_data[0];
				REG_ENTRY_COUNT: count_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q    <= '0;
			hi_p1_q <= '0;
			addr_q  <= '0;
			cmp_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == REQ_SEARCH) begin
						lo_q    <= '0;
						hi_p1_q <= used_count;
						cmp_q   <= '0;
						found_q <= 1'b0;
						state_q <= (used_count == '0) ? ST_DONE : ST_RD;
					end
				end
				ST_RD: begin
					addr_q  <= probe;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cmp_q   <= cmp_q + CNT_W'(1);
					found_q <= match;
					lo_q    <= next_lo;
					hi_p1_q <= next_hi_p1;
					state_q <= (match || !(next_lo < next_hi_p1)) ? ST_DONE : ST_RD;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search key capture
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_key;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= found_q;
			out_cmp_q   <= cmp_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_DATA_W-M_DATA_BITS){1'b0}}, out_cmp_q, out_found_q};

	// checks
	`TKS_ASSERT(a_cmp_bound, cmp_q <= CNT_W'(TABLE_DEPTH))
	`TKS_ASSERT(a_probe_in_range, (state_q == ST_RD) |-> (lo_q < hi_p1_q))
	`TKS_ASSERT(a_cmp_step, (state_q == ST_CMP) |=> (cmp_q == $past(cmp_q) + CNT_W'(1)))
	`TKS_NEVER(a_found_needs_cmp, m_valid_q && out_found_q && (out_cmp_q == '0))

endmodule

`default_nettype wire
